// ===== sv/lalws_pkg.sv =====
package lalws_pkg;

    // Default parameter values
    localparam int NUM_TARGETS_DEF    = 4;
    localparam int EXPLORE_PERIOD_DEF = 10;

    // Field and state widths
    localparam int MAX_LANES  = 4;
    localparam int AVG_W      = 20;
    localparam int LAT_W      = 16;
    localparam int BIAS_W     = 16;
    localparam int WGT_W      = 8;
    localparam int TOTAL_W    = 10;
    localparam int SCORE_W    = 22;
    localparam int DRAW_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int TIDX_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Register reset values
    localparam logic [MAX_LANES-1:0]       RST_AVAIL   = 4'hF;
    localparam logic [MAX_LANES*WGT_W-1:0] RST_WEIGHTS = 32'h0101_0101;
    localparam logic [MAX_LANES*BIAS_W-1:0] RST_BIASES = 64'h0;

    // Request modes
    localparam logic MODE_SELECT = 1'b0;
    localparam logic MODE_RECORD = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVAIL   = 2'd0,
        CFG_WEIGHTS = 2'd1,
        CFG_BIASES  = 2'd2
    } t_cfg_reg;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_EXPLORED = 3'd0,
        ST_LOWEST   = 3'd1,
        ST_WEIGHTED = 3'd2,
        ST_NONE     = 3'd3,
        ST_RECORDED = 3'd4,
        ST_IGNORED  = 3'd5
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_REC,
        S_EXP_PICK,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_WGT_MOD,
        S_PUSH
    } t_state;

    // Weight of one lane, zero reads as one
    function automatic logic [WGT_W-1:0] lane_weight(
        input logic [MAX_LANES*WGT_W-1:0] weights,
        input int                         lane
    );
        logic [WGT_W-1:0] w;
        w = weights[WGT_W*lane +: WGT_W];
        return (w == '0) ? WGT_W'(1) : w;
    endfunction

endpackage

// ===== sv/lalws_ram.sv =====
module lalws_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lalws_rem.sv =====
module lalws_rem #(
    parameter int DIV_W = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lalws_pkg::DRAW_W-1:0]  i_dividend,
    input  logic [DIV_W-1:0]              i_divisor,
    output logic                          o_done,
    output logic [DIV_W-1:0]              o_rem
);
    import lalws_pkg::*;

    localparam int CNT_W = $clog2(DRAW_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DRAW_W-1:0] r_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dvs;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_rem, r_quo[DRAW_W-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DRAW_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath, no reset
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DRAW_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                r_rem <= diff[DIV_W-1:0];
            end else begin
                r_rem <= trial[DIV_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== sv/latency_aware_weighted_selector.sv =====
// Latency-aware target selector. A record request (mode 1) folds a latency
// sample into the target's average (first sample loads, later ones 3/4 old plus
// 1/4 new in Q.4); the average is written in S_REC and the result then waits
// in S_PUSH for the output register. A select request (mode 0) draws the
// 32-bit call counter; every EXPLORE_PERIOD-th draw explores an available
// target with no average yet, otherwise the available target with the lowest
// average plus bias wins, and with no averages a weighted pick is made from a
// second draw. The explore test needs no division: a phase counter follows the
// call counter modulo EXPLORE_PERIOD. The explore pick and the weighted pick
// use the shared remainder unit, which retires one dividend bit per cycle, and
// the scan reads the average memory through its single read port. One request
// is in work at a time; a new request is taken while the previous result still
// waits in the output register. No clearing pass after reset.
module latency_aware_weighted_selector #(
    parameter int NUM_TARGETS    = lalws_pkg::NUM_TARGETS_DEF,
    parameter int EXPLORE_PERIOD = lalws_pkg::EXPLORE_PERIOD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [lalws_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lalws_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [lalws_pkg::TIDX_W-1:0]      i_target_index,
    input  logic [lalws_pkg::LAT_W-1:0]       i_latency_ms,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lalws_pkg::STATUS_W-1:0]    o_status,
    output logic [lalws_pkg::TIDX_W-1:0]      o_chosen_index,
    output logic signed [lalws_pkg::SCORE_W-1:0] o_best_score_q4
);
    import lalws_pkg::*;

    localparam int LANES  = (NUM_TARGETS < MAX_LANES) ? NUM_TARGETS : MAX_LANES;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int PER_W  = $clog2(EXPLORE_PERIOD);
    localparam int DIV_W  = TOTAL_W;
    localparam int SUM_W  = AVG_W + 3;
    localparam int CNT_W  = $clog2(MAX_LANES + 1);

    // configuration registers
    logic [MAX_LANES-1:0]        r_avail;
    logic [MAX_LANES*WGT_W-1:0]  r_weights;
    logic [MAX_LANES*BIAS_W-1:0] r_biases;

    // control state
    t_state                      r_state, n_state;
    logic [DRAW_W-1:0]           r_count, n_count;
    logic [PER_W-1:0]            r_phase, n_phase;
    logic [PER_W-1:0]            phase_inc;
    logic [LANES-1:0]            r_known, n_known;
    logic [LANE_W-1:0]           r_tgt, n_tgt;
    logic [LANE_W-1:0]           r_idx, n_idx;
    logic                        r_found, n_found;
    logic signed [SCORE_W-1:0]   r_best, n_best;
    logic [LANE_W-1:0]           r_best_i, n_best_i;
    logic [LAT_W-1:0]            r_lat, n_lat;

    // pending result
    t_status                     r_status, n_status;
    logic [LANE_W-1:0]           r_chosen, n_chosen;
    logic signed [SCORE_W-1:0]   r_score, n_score;

    // output register
    logic                        r_out_valid;
    t_status                     r_o_status;
    logic [TIDX_W-1:0]           r_o_chosen;
    logic signed [SCORE_W-1:0]   r_o_score;

    logic                        in_accept;
    logic                        load_out;

    // memory and remainder unit hookup
    logic                        ram_we;
    logic [LANE_W-1:0]           ram_raddr;
    logic [AVG_W-1:0]            ram_rdata;
    logic [AVG_W-1:0]            rec_avg;
    logic [SUM_W-1:0]            rec_sum;
    logic                        div_start;
    logic [DRAW_W-1:0]           div_dividend;
    logic [DIV_W-1:0]            div_divisor;
    logic                        div_done;
    logic [DIV_W-1:0]            div_rem;

    // lane summaries
    logic [LANES-1:0]            avail_vec;
    logic [LANES-1:0]            unk_vec;
    logic [CNT_W-1:0]            unk_cnt;
    logic [TOTAL_W-1:0]          total;
    logic [LANE_W-1:0]           pick_lane;
    logic [LANE_W-1:0]           wgt_lane;
    logic signed [SCORE_W-1:0]   lane_score;
    logic [BIAS_W-1:0]           lane_bias;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // average store
    lalws_ram #(
        .WIDTH  (AVG_W),
        .DEPTH  (LANES),
        .ADDR_W (LANE_W)
    ) u_avg_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tgt),
        .i_wdata (rec_avg),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared bit-serial remainder
    lalws_rem #(
        .DIV_W (DIV_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // per-lane availability, unknown count and total weight
    always_comb begin
        unk_cnt = '0;
        total   = '0;
        for (int i = 0; i < LANES; i++) begin
            avail_vec[i] = r_avail[i];
            unk_vec[i]   = r_avail[i] && !r_known[i];
            unk_cnt      = unk_cnt + CNT_W'(unk_vec[i]);
            if (r_avail[i]) begin
                total = total + TOTAL_W'(lane_weight(r_weights, i));
            end
        end
    end

    // call counter modulo EXPLORE_PERIOD; restarts when the counter wraps
    assign phase_inc = (r_count == '1 || r_phase == PER_W'(EXPLORE_PERIOD - 1)) ?
                       '0 : r_phase + PER_W'(1);

    // explore pick: k-th available unknown lane, k from the remainder
    always_comb begin
        logic [CNT_W-1:0] seen;
        logic             hit;
        seen      = '0;
        hit       = 1'b0;
        pick_lane = '0;
        for (int i = 0; i < LANES; i++) begin
            if (unk_vec[i]) begin
                if (!hit && (seen == div_rem[CNT_W-1:0])) begin
                    hit       = 1'b1;
                    pick_lane = LANE_W'(i);
                end
                seen = seen + 1'b1;
            end
        end
    end

    // weighted walk: first available lane whose running weight passes the slot
    always_comb begin
        logic [TOTAL_W-1:0] cum;
        logic               hit;
        cum      = '0;
        hit      = 1'b0;
        wgt_lane = '0;
        for (int i = 0; i < LANES; i++) begin
            if (avail_vec[i] && !hit) begin
                wgt_lane = LANE_W'(i);
                cum      = cum + TOTAL_W'(lane_weight(r_weights, i));
                if (div_rem < DIV_W'(cum)) begin
                    hit = 1'b1;
                end
            end
        end
    end

    // score of the lane under scan: average + 16 * bias
    assign lane_bias  = r_biases[BIAS_W*r_idx +: BIAS_W];
    assign lane_score = $signed({2'b00, ram_rdata})
                      + $signed({{2{lane_bias[BIAS_W-1]}}, lane_bias, 4'b0000});

    // average update: first sample loads, later (3*avg + sample) / 4
    assign rec_sum = SUM_W'({ram_rdata, 1'b0}) + SUM_W'(ram_rdata)
                   + SUM_W'({r_lat, 4'b0000});
    assign rec_avg = r_known[r_tgt] ? rec_sum[AVG_W+1:2] : AVG_W'({r_lat, 4'b0000});

    // sequencer: next state and datapath controls
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_phase      = r_phase;
        n_known      = r_known;
        n_tgt        = r_tgt;
        n_idx        = r_idx;
        n_found      = r_found;
        n_best       = r_best;
        n_best_i     = r_best_i;
        n_lat        = r_lat;
        n_status     = r_status;
        n_chosen     = r_chosen;
        n_score      = r_score;
        ram_we       = 1'b0;
        ram_raddr    = r_idx;
        div_start    = 1'b0;
        div_dividend = r_count;
        div_divisor  = DIV_W'(total);
        load_out     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = i_target_index[LANE_W-1:0];
                if (in_accept) begin
                    n_chosen = '0;
                    n_score  = '0;
                    if (i_mode == MODE_RECORD) begin
                        if (i_latency_ms == '0 ||
                            32'(i_target_index) >= 32'(NUM_TARGETS)) begin
                            n_status = ST_IGNORED;
                            n_state  = S_PUSH;
                        end else begin
                            n_tgt   = i_target_index[LANE_W-1:0];
                            n_lat   = i_latency_ms;
                            n_state = S_REC;
                        end
                    end else if (avail_vec == '0) begin
                        n_status = ST_NONE;
                        n_state  = S_PUSH;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_phase = phase_inc;
                        if (unk_vec != '0 && r_phase == '0) begin
                            // explore draw: pick unknown number draw mod unknowns
                            div_start    = 1'b1;
                            div_dividend = r_count;
                            div_divisor  = DIV_W'(unk_cnt);
                            n_state      = S_EXP_PICK;
                        end else begin
                            n_idx   = '0;
                            n_found = 1'b0;
                            n_state = S_SCAN_RD;
                        end
                    end
                end
            end

            S_REC: begin
                ram_we         = 1'b1;
                n_known[r_tgt] = 1'b1;
                n_status       = ST_RECORDED;
                n_state        = S_PUSH;
            end

            S_EXP_PICK: begin
                if (div_done) begin
                    n_status = ST_EXPLORED;
                    n_chosen = pick_lane;
                    n_state  = S_PUSH;
                end
            end

            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end

            S_SCAN_CMP: begin
                if (avail_vec[r_idx] && r_known[r_idx] &&
                    (!r_found || lane_score < r_best)) begin
                    n_found  = 1'b1;
                    n_best   = lane_score;
                    n_best_i = r_idx;
                end
                if (r_idx == LANE_W'(LANES - 1)) begin
                    if (n_found) begin
                        n_status = ST_LOWEST;
                        n_chosen = n_best_i;
                        n_score  = n_best;
                        n_state  = S_PUSH;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = r_count;
                        div_divisor  = DIV_W'(total);
                        n_count      = r_count + 1'b1;
                        n_phase      = phase_inc;
                        n_state      = S_WGT_MOD;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end

            S_WGT_MOD: begin
                if (div_done) begin
                    n_status = ST_WEIGHTED;
                    n_chosen = wgt_lane;
                    n_state  = S_PUSH;
                end
            end

            S_PUSH: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_phase     <= '0;
            r_known     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_avail     <= RST_AVAIL;
            r_weights   <= RST_WEIGHTS;
            r_biases    <= RST_BIASES;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_phase <= n_phase;
            r_known <= n_known;
            r_found <= n_found;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_AVAIL:   r_avail   <= i_cfg_data[MAX_LANES-1:0];
                    CFG_WEIGHTS: r_weights <= i_cfg_data[MAX_LANES*WGT_W-1:0];
                    CFG_BIASES:  r_biases  <= i_cfg_data[MAX_LANES*BIAS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_tgt    <= n_tgt;
        r_idx    <= n_idx;
        r_best   <= n_best;
        r_best_i <= n_best_i;
        r_lat    <= n_lat;
        r_status <= n_status;
        r_chosen <= n_chosen;
        r_score  <= n_score;
        if (load_out) begin
            r_o_status <= r_status;
            r_o_chosen <= TIDX_W'(r_chosen);
            r_o_score  <= r_score;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_chosen_index  = r_o_chosen;
    assign o_best_score_q4 = r_o_score;

endmodule

// ===== dv/latency_aware_weighted_selector_tb.sv =====
`timescale 1ns / 100ps

module latency_aware_weighted_selector_tb;
    import lalws_pkg::*;

    localparam int N_LANES       = 4;
    localparam int EXPLORE_EVERY = 10;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int N_PHASES      = 12;
    localparam int PHASE_ITEMS   = 50;

    typedef struct packed {
        t_status             status;
        logic [TIDX_W-1:0]   chosen;
        logic [SCORE_W-1:0]  score;
    } t_outcome;

    typedef struct {
        logic               mode;
        logic [TIDX_W-1:0]  tgt;
        logic [LAT_W-1:0]   lat;
        bit                 hold;   // present only once all results are back
    } t_request;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic                         i_mode = 1'b0;
    logic [TIDX_W-1:0]            i_target_index = '0;
    logic [LAT_W-1:0]             i_latency_ms = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [STATUS_W-1:0]          o_status;
    logic [TIDX_W-1:0]            o_chosen_index;
    logic signed [SCORE_W-1:0]    o_best_score_q4;

    // shadow copies of the registers and of the selector state
    logic [MAX_LANES-1:0]         sh_avail = RST_AVAIL;
    logic [MAX_LANES*WGT_W-1:0]   sh_weights = RST_WEIGHTS;
    logic [MAX_LANES*BIAS_W-1:0]  sh_biases = RST_BIASES;
    logic [AVG_W-1:0]             avg_q4 [N_LANES];
    bit                           known [N_LANES];
    logic [DRAW_W-1:0]            call_cnt = '0;

    t_request  req_queue[$];
    t_outcome  due_outcomes[$];
    int        snd_idle_pct = 31;
    int        rcv_stall_pct = 50;
    int        mismatch_cnt = 0;
    int        quiet_cycles = 0;

    latency_aware_weighted_selector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_target_index  (i_target_index),
        .i_latency_ms    (i_latency_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_chosen_index  (o_chosen_index),
        .o_best_score_q4 (o_best_score_q4)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // weight of one target, zero counts as one
    function automatic int lane_share(input int lane);
        int w;
        w = sh_weights[WGT_W*lane +: WGT_W];
        return (w == 0) ? 1 : w;
    endfunction

    // expected outcome of one request; updates averages and the call counter
    function automatic t_outcome compute_outcome(
        input logic              mode,
        input logic [TIDX_W-1:0] tgt,
        input logic [LAT_W-1:0]  lat
    );
        t_outcome                   res;
        int                         n_avail, n_unknown, total, k, slot, cum, last, s, best;
        bit                         found;
        logic [DRAW_W-1:0]          draw;
        logic [AVG_W-1:0]           sample;
        logic signed [BIAS_W-1:0]   bias16;
        res.status = ST_IGNORED;
        res.chosen = '0;
        res.score  = '0;

        // latency sample
        if (mode == MODE_RECORD) begin
            if (lat != '0) begin
                sample = {lat, 4'b0000};
                if (!known[tgt])
                    avg_q4[tgt] = sample;
                else
                    avg_q4[tgt] = AVG_W'((32'(avg_q4[tgt]) * 3 + 32'(sample)) >> 2);
                known[tgt] = 1'b1;
                res.status = ST_RECORDED;
            end
            return res;
        end

        n_avail = 0;
        n_unknown = 0;
        total = 0;
        for (int i = 0; i < N_LANES; i++) begin
            if (sh_avail[i]) begin
                n_avail++;
                total += lane_share(i);
                if (!known[i])
                    n_unknown++;
            end
        end
        if (n_avail == 0) begin
            res.status = ST_NONE;
            return res;
        end

        // exploration on every tenth draw
        draw = call_cnt;
        call_cnt = call_cnt + 1;
        if (n_unknown != 0 && (draw % EXPLORE_EVERY) == 0) begin
            k = draw % n_unknown;
            for (int i = 0; i < N_LANES; i++) begin
                if (sh_avail[i] && !known[i]) begin
                    if (k == 0) begin
                        res.status = ST_EXPLORED;
                        res.chosen = TIDX_W'(i);
                        return res;
                    end
                    k--;
                end
            end
        end

        // lowest average plus bias, ties to lowest index
        found = 1'b0;
        best = 0;
        last = 0;
        for (int i = 0; i < N_LANES; i++) begin
            if (sh_avail[i] && known[i]) begin
                bias16 = sh_biases[BIAS_W*i +: BIAS_W];
                s = int'(avg_q4[i]) + int'(bias16) * 16;
                if (!found || s < best) begin
                    found = 1'b1;
                    best = s;
                    last = i;
                end
            end
        end
        if (found) begin
            res.status = ST_LOWEST;
            res.chosen = TIDX_W'(last);
            res.score  = SCORE_W'(best);
            return res;
        end

        // weighted pick from a second draw
        draw = call_cnt;
        call_cnt = call_cnt + 1;
        slot = draw % total;
        cum = 0;
        last = 0;
        for (int i = 0; i < N_LANES; i++) begin
            if (sh_avail[i]) begin
                last = i;
                cum += lane_share(i);
                if (slot < cum)
                    break;
            end
        end
        res.status = ST_WEIGHTED;
        res.chosen = TIDX_W'(last);
        return res;
    endfunction

    // request driver
    always @(posedge i_clk) begin : drive_requests
        t_request r;
        bit       ready;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            ready = !i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                due_outcomes.insert(due_outcomes.size(),
                                    compute_outcome(i_mode, i_target_index, i_latency_ms));
                ready = 1'b1;
            end
            if (ready) begin
                if (req_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct &&
                    !(req_queue[0].hold && due_outcomes.size() != 0)) begin
                    r = req_queue.pop_front();
                    i_in_valid     <= 1'b1;
                    i_mode         <= r.mode;
                    i_target_index <= r.tgt;
                    i_latency_ms   <= r.lat;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result checker and receiver stall
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_outcomes.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: status %0d chosen %0d score %0d",
                                 o_status, o_chosen_index, o_best_score_q4);
                end else begin
                    want = due_outcomes.pop_front();
                    if (o_status !== want.status || o_chosen_index !== want.chosen ||
                        o_best_score_q4 !== want.score) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: exp status %0d chosen %0d score %0d, %s",
                                     want.status, want.chosen, $signed(want.score),
                                     $sformatf("got %0d %0d %0d", o_status,
                                               o_chosen_index, o_best_score_q4));
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            CFG_AVAIL:   sh_avail   = val[MAX_LANES-1:0];
            CFG_WEIGHTS: sh_weights = val[MAX_LANES*WGT_W-1:0];
            CFG_BIASES:  sh_biases  = val[MAX_LANES*BIAS_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every request is sent and every result is back
    task automatic drain();
        while (req_queue.size() != 0 || i_in_valid || due_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_select(input bit hold);
        t_request r;
        r.mode = MODE_SELECT;
        r.tgt  = TIDX_W'($urandom_range(3));
        r.lat  = LAT_W'($urandom);
        r.hold = hold;
        req_queue.insert(req_queue.size(), r);
    endtask

    task automatic add_record(input int tgt, input int lat, input bit hold);
        t_request r;
        r.mode = MODE_RECORD;
        r.tgt  = TIDX_W'(tgt);
        r.lat  = LAT_W'(lat);
        r.hold = hold;
        req_queue.insert(req_queue.size(), r);
    endtask

    initial begin : run_test
        int                      tgt, lat, pick;
        logic [MAX_LANES-1:0]    rec_set;
        for (int i = 0; i < N_LANES; i++) begin
            avg_q4[i] = '0;
            known[i]  = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: explore, weighted picks, ignored sample, tie, bias extremes
        add_select(1'b0);
        add_select(1'b0);
        add_select(1'b0);
        add_record(0, 0, 1'b0);
        add_record(3, 16'hFFFF, 1'b0);
        add_record(2, 16'hFFFF, 1'b1);
        add_select(1'b1);
        add_record(3, 1, 1'b0);
        add_select(1'b0);
        drain();
        write_reg(CFG_BIASES, 64'h7FFF_8000_0000_0000);
        add_select(1'b0);
        drain();
        write_reg(CFG_AVAIL, '0);
        add_select(1'b0);
        add_record(1, 0, 1'b0);
        drain();
        write_reg(CFG_AVAIL, 64'h3);
        write_reg(CFG_WEIGHTS, '0);
        repeat (3) add_select(1'b0);
        drain();
        write_reg(CFG_WEIGHTS, 64'hFFFF_FFFF);
        repeat (2) add_select(1'b0);
        drain();

        // random phases; targets 0 and 1 stay unknown early so explore and
        // weighted picks keep being reachable
        for (int p = 0; p < N_PHASES; p++) begin
            snd_idle_pct  = (p < 4) ? 31 : (p < 8) ? 50 : 0;
            rcv_stall_pct = (p < 4) ? 50 : (p < 8) ? 31 : 0;
            rec_set = (p < 4) ? 4'b1100 : (p < 8) ? 4'b1110 : 4'b1111;
            write_reg(CFG_AVAIL, (p == 0) ? 64'hF : (p == 5) ? 64'h0 :
                      64'($urandom_range(15)));
            write_reg(CFG_WEIGHTS, (p == 1) ? 64'h0 : (p == 2) ? 64'hFFFF_FFFF :
                      64'($urandom));
            write_reg(CFG_BIASES, (p == 3) ? 64'h8000_8000_8000_8000 :
                      (p == 4) ? 64'h7FFF_7FFF_7FFF_7FFF : {$urandom, $urandom});
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(1) == 0) begin
                    add_select($urandom_range(49) == 0);
                end else begin
                    do tgt = $urandom_range(3); while (!rec_set[tgt]);
                    pick = $urandom_range(9);
                    unique case (pick)
                        0: lat = 0;
                        1: lat = 16'hFFFF;
                        2: lat = $urandom_range(1, 15);
                        3: lat = $urandom_range(1, 4);
                        default: lat = $urandom_range(1, 65535);
                    endcase
                    add_record(tgt, lat, $urandom_range(49) == 0);
                end
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && due_outcomes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
